/* src/wsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

	localparam int LENGTH_BITS = 64;
	localparam int OUT_LEN_W   = 64;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	localparam logic ERR_OPCODE   = 1'b0;
	localparam logic ERR_RESERVED = 1'b1;

	localparam logic [3:0] OP_CONT   = 4'd0;
	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	localparam logic [6:0] LEN_CODE_SHORT_MAX = 7'd125;
	localparam logic [6:0] LEN_CODE_16        = 7'd126;
	localparam logic [6:0] LEN_CODE_64        = 7'd127;

	localparam logic [2:0] EXT16_CNT = 3'd1;
	localparam logic [2:0] EXT64_CNT = 3'd7;
	localparam logic [2:0] KEY_CNT   = 3'd3;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} byte_stage_t;

	typedef struct packed {
		kind_t                kind;
		logic                 fin;
		logic [3:0]           opcode;
		logic                 masked;
		logic [OUT_LEN_W-1:0] length;
		logic [7:0]           pbyte;
		logic                 last;
		logic                 close;
		logic                 err;
	} res_t;

	function automatic logic opcode_ok(input logic [3:0] op);
		return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
			(op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
	endfunction

endpackage

`default_nettype wire

/* src/wsd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

/* src/wsd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wsd_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    result_kind;
	logic                          fin_flag;
	logic [3:0]                    frame_opcode;
	logic                          masked_flag;
	logic [wsd_pkg::OUT_LEN_W-1:0] payload_length;
	logic [7:0]                    payload_byte;
	logic                          last_of_frame;
	logic                          close_frame;
	logic                          error_code;

	modport source (
		output valid, input ready,
		output result_kind, output fin_flag, output frame_opcode, output masked_flag,
		output payload_length, output payload_byte, output last_of_frame,
		output close_frame, output error_code
	);
	modport sink (
		input valid, output ready,
		input result_kind, input fin_flag, input frame_opcode, input masked_flag,
		input payload_length, input payload_byte, input last_of_frame,
		input close_frame, input error_code
	);
endinterface

`default_nettype wire

/* src/wsd_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsd_in_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	wsd_in_if.sink               bytes,
	input  wire                  advance,
	output wsd_pkg::byte_stage_t stage
);
	import wsd_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;

	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_s1 <= bytes.data_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = data_s1;

endmodule

`default_nettype wire

/* src/wsd_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire wsd_pkg::byte_stage_t stage,
	output logic                 advance,
	wsd_out_if.source            results
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD,
		PH_DEAD
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [2:0]             cnt_q, cnt_d;
	logic                   fin_q, fin_d;
	logic [3:0]             op_q, op_d;
	logic                   mask_q, mask_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [31:0]            key_q, key_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [1:0]             off_q, off_d;

	logic       out_valid_q;
	res_t       res_q, res_d;
	logic       produce;
	logic       fire;
	logic       hdr_done;
	logic       len_done;
	logic [7:0] b;
	logic [7:0] key_byte;
	kind_t      kind;
	logic [7:0] pbyte;
	logic       last;
	logic       err;

	assign advance = !out_valid_q || results.ready;
	assign fire    = stage.valid && advance;
	assign b       = stage.data;

	assign key_byte = 8'(key_q >> {~off_q, 3'b000});

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		fin_d    = fin_q;
		op_d     = op_q;
		mask_d   = mask_q;
		len_d    = len_q;
		key_d    = key_q;
		rem_d    = rem_q;
		off_d    = off_q;
		produce  = 1'b0;
		hdr_done = 1'b0;
		len_done = 1'b0;
		kind     = KIND_HEADER;
		pbyte    = 8'd0;
		last     = 1'b0;
		err      = ERR_OPCODE;
		unique case (phase_q)
			PH_SECOND: begin
				mask_d = b[7];
				if (b[6:0] <= LEN_CODE_SHORT_MAX) begin
					len_d    = LENGTH_BITS'(b[6:0]);
					len_done = 1'b1;
				end else begin
					cnt_d   = (b[6:0] == LEN_CODE_16) ? EXT16_CNT : EXT64_CNT;
					phase_d = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				if (|len_q[LENGTH_BITS-1 -: 8]) begin
					len_d = LEN_MAX;
				end else begin
					len_d = {len_q[LENGTH_BITS-9:0], b};
				end
				if (cnt_q == 3'd0) begin
					len_done = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], b};
				if (cnt_q == 3'd0) begin
					hdr_done = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_PAYLOAD: begin
				produce = 1'b1;
				kind    = KIND_PAYLOAD;
				pbyte   = b ^ key_byte;
				last    = (rem_q == LENGTH_BITS'(1));
				rem_d   = rem_q - LENGTH_BITS'(1);
				off_d   = off_q + 2'd1;
				if (last) begin
					phase_d = PH_FIRST;
				end
			end
			PH_DEAD: begin
			end
			default: begin
				fin_d  = b[7];
				op_d   = b[3:0];
				mask_d = 1'b0;
				len_d  = '0;
				key_d  = '0;
				cnt_d  = 3'd0;
				off_d  = 2'd0;
				if (!opcode_ok(b[3:0])) begin
					produce = 1'b1;
					kind    = KIND_ERROR;
					err     = ERR_OPCODE;
					phase_d = PH_DEAD;
				end else if (b[6:4] != 3'd0) begin
					produce = 1'b1;
					kind    = KIND_ERROR;
					err     = ERR_RESERVED;
					phase_d = PH_DEAD;
				end else begin
					phase_d = PH_SECOND;
				end
			end
		endcase
		if (len_done) begin
			if (mask_d) begin
				cnt_d   = KEY_CNT;
				phase_d = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end
		if (hdr_done) begin
			produce = 1'b1;
			kind    = KIND_HEADER;
			last    = (len_d == '0);
			rem_d   = len_d;
			off_d   = 2'd0;
			phase_d = last ? PH_FIRST : PH_PAYLOAD;
		end
		res_d.kind   = kind;
		res_d.fin    = fin_d;
		res_d.opcode = op_d;
		res_d.masked = mask_d;
		res_d.length = OUT_LEN_W'(len_d);
		res_d.pbyte  = pbyte;
		res_d.last   = last;
		res_d.close  = (op_d == OP_CLOSE);
		res_d.err    = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			cnt_q       <= 3'd0;
			fin_q       <= 1'b0;
			op_q        <= 4'd0;
			mask_q      <= 1'b0;
			len_q       <= '0;
			key_q       <= '0;
			rem_q       <= '0;
			off_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				fin_q   <= fin_d;
				op_q    <= op_d;
				mask_q  <= mask_d;
				len_q   <= len_d;
				key_q   <= key_d;
				rem_q   <= rem_d;
				off_q   <= off_d;
			end
			if (advance) begin
				out_valid_q <= fire && produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			res_q <= res_d;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.result_kind    = res_q.kind;
	assign results.fin_flag       = res_q.fin;
	assign results.frame_opcode   = res_q.opcode;
	assign results.masked_flag    = res_q.masked;
	assign results.payload_length = res_q.length;
	assign results.payload_byte   = res_q.pbyte;
	assign results.last_of_frame  = res_q.last;
	assign results.close_frame    = res_q.close;
	assign results.error_code     = res_q.err;

`ifndef SYNTHESIS
	a_dead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DEAD |-> !produce)
		else $error("result produced after error");

	a_err_kills: assert property (@(posedge clk) disable iff (!arst_n)
		fire && produce && kind == KIND_ERROR |=> phase_q == PH_DEAD)
		else $error("error did not stop parsing");

	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with nothing left");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && produce && last |=> phase_q == PH_FIRST)
		else $error("last word did not return to frame start");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* src/websocket_frame_deframer_top.sv */
// Channel   Role    Payload
// bytes     sink    data_byte: raw frame stream, one byte per word
// results   source  result_kind, fin_flag, frame_opcode, masked_flag, payload_length,
//                   payload_byte, last_of_frame, close_frame, error_code
//
// One byte per cycle while results is not stalled. Input register, then parser state
// and result register; only the last header byte gives a word, a header word.
// arst_n clears parser state and both valid flags; after an error all bytes drop until reset.
// A stalled result holds the result register; the input register keeps accepting while
// the result register can drain in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top (
	input  wire       clk,
	input  wire       arst_n,
	wsd_in_if.sink    bytes,
	wsd_out_if.source results
);
	import wsd_pkg::*;

	byte_stage_t stage;
	logic        advance;

	wsd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.advance (advance),
		.stage   (stage)
	);

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.advance (advance),
		.results (results)
	);

endmodule

`default_nettype wire

/* sim/websocket_frame_deframer_top_test.sv */
`timescale 1ns / 1ps

module websocket_frame_deframer_top_test;
	import wsd_pkg::*;

	localparam int RANDOM_BYTES = 1550;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 250;
	localparam res_t NO_WORD    = '0;

	typedef enum logic [2:0] {
		ST_FIRST, ST_SECOND, ST_EXTLEN, ST_KEY, ST_PAYLOAD, ST_DEAD
	} parse_st_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		res_t       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	wsd_in_if  in_ch ();
	wsd_out_if out_ch ();

	websocket_frame_deframer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(in_ch),
		.results(out_ch)
	);

	always #5 clk = ~clk;

	// parser mirror
	parse_st_t   m_st;
	logic [2:0]  m_cnt;
	logic        m_fin;
	logic [3:0]  m_op;
	logic        m_mask;
	logic [63:0] m_len;
	logic [31:0] m_key;
	logic [63:0] m_off;

	res_t expected_words[$];
	int   errors;
	int   sent;
	int   cycles;
	int   send_idle;
	int   recv_idle;
	int   hold_asked;
	int   hold_taken;
	int   hold_left;

	function automatic bit op_known(input logic [3:0] op);
		return op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
			op == OP_CLOSE || op == OP_PING || op == OP_PONG;
	endfunction

	function automatic res_t typed_word(input kind_t k, input logic fin, input logic [3:0] op,
			input logic masked, input logic [63:0] len, input logic last, input logic cls,
			input logic err);
		res_t w;
		w = '0;
		w.kind = k;
		w.fin = fin;
		w.opcode = op;
		w.masked = masked;
		w.length = len;
		w.last = last;
		w.close = cls;
		w.err = err;
		return w;
	endfunction

	function automatic res_t state_word(input kind_t k, input logic [7:0] pb, input logic last,
			input logic err);
		res_t w;
		w = typed_word(k, m_fin, m_op, m_mask, m_len, last, m_op == OP_CLOSE, err);
		w.pbyte = pb;
		return w;
	endfunction

	function automatic res_t header_word();
		res_t w;
		w = state_word(KIND_HEADER, 8'h00, m_len == 0, 1'b0);
		m_off = '0;
		m_st = (m_len == 0) ? ST_FIRST : ST_PAYLOAD;
		return w;
	endfunction

	function automatic bit length_done(output res_t w);
		w = NO_WORD;
		if (m_mask) begin
			m_cnt = KEY_CNT;
			m_st = ST_KEY;
			return 1'b0;
		end
		w = header_word();
		return 1'b1;
	endfunction

	function automatic bit deframe_step(input logic [7:0] b, output res_t w);
		logic [71:0] nxt;
		logic [7:0]  kb;
		logic        last;
		w = NO_WORD;
		case (m_st)
			ST_SECOND: begin
				m_mask = b[7];
				if (b[6:0] <= LEN_CODE_SHORT_MAX) begin
					m_len = 64'(b[6:0]);
					return length_done(w);
				end
				m_cnt = (b[6:0] == LEN_CODE_16) ? EXT16_CNT : EXT64_CNT;
				m_st = ST_EXTLEN;
				return 1'b0;
			end
			ST_EXTLEN: begin
				if (m_len > 64'(LEN_MAX >> 8)) begin
					m_len = 64'(LEN_MAX);
				end else begin
					nxt = {m_len, b};
					m_len = (nxt > 72'(LEN_MAX)) ? 64'(LEN_MAX) : nxt[63:0];
				end
				if (m_cnt == 0)
					return length_done(w);
				m_cnt = m_cnt - 3'd1;
				return 1'b0;
			end
			ST_KEY: begin
				m_key = {m_key[23:0], b};
				if (m_cnt == 0) begin
					w = header_word();
					return 1'b1;
				end
				m_cnt = m_cnt - 3'd1;
				return 1'b0;
			end
			ST_PAYLOAD: begin
				kb = 8'(m_key >> (8 * (3 - m_off[1:0])));
				m_off = m_off + 64'd1;
				last = m_off >= m_len;
				w = state_word(KIND_PAYLOAD, b ^ kb, last, 1'b0);
				if (last)
					m_st = ST_FIRST;
				return 1'b1;
			end
			ST_DEAD: begin
				return 1'b0;
			end
			default: begin
				m_fin = b[7];
				m_op = b[3:0];
				m_mask = 1'b0;
				m_len = '0;
				m_key = '0;
				m_off = '0;
				m_cnt = '0;
				if (!op_known(m_op)) begin
					w = state_word(KIND_ERROR, 8'h00, 1'b0, ERR_OPCODE);
					m_st = ST_DEAD;
					return 1'b1;
				end
				if (b[6:4] != 0) begin
					w = state_word(KIND_ERROR, 8'h00, 1'b0, ERR_RESERVED);
					m_st = ST_DEAD;
					return 1'b1;
				end
				m_st = ST_SECOND;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b, input bit typed, input res_t want);
		res_t w;
		bit   got;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		got = deframe_step(b, w);
		if (typed)
			w = want;
		if (got || typed)
			expected_words.push_back(w);
		sent++;
	endtask

	task automatic send_frame();
		logic [3:0]  op;
		logic [63:0] len;
		logic [6:0]  code;
		logic        masked;
		logic [31:0] key;
		int          sel;
		case ($urandom_range(5))
			0: op = OP_CONT;
			1: op = OP_TEXT;
			2: op = OP_BINARY;
			3: op = OP_CLOSE;
			4: op = OP_PING;
			default: op = OP_PONG;
		endcase
		sel = $urandom_range(99);
		if (sel < 55) begin
			len = 64'($urandom_range(16));
			code = 7'(len);
		end else if (sel < 70) begin
			len = 64'($urandom_range(125));
			code = 7'(len);
		end else if (sel < 85) begin
			len = 64'($urandom_range(300));
			code = LEN_CODE_16;
		end else begin
			len = 64'($urandom_range(40));
			code = LEN_CODE_64;
		end
		masked = 1'($urandom_range(1));
		key = $urandom;
		put_byte({1'($urandom_range(1)), 3'b000, op}, 1'b0, NO_WORD);
		put_byte({masked, code}, 1'b0, NO_WORD);
		if (code == LEN_CODE_16) begin
			put_byte(len[15:8], 1'b0, NO_WORD);
			put_byte(len[7:0], 1'b0, NO_WORD);
		end else if (code == LEN_CODE_64) begin
			for (int i = 7; i >= 0; i--)
				put_byte(len[8*i +: 8], 1'b0, NO_WORD);
		end
		if (masked)
			for (int i = 3; i >= 0; i--)
				put_byte(key[8*i +: 8], 1'b0, NO_WORD);
		for (int j = 0; j < len; j++)
			put_byte(8'($urandom_range(255)), 1'b0, NO_WORD);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// result word checker
	always @(posedge clk) begin
		res_t w;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual kind %0d byte %0h",
					$time, out_ch.result_kind, out_ch.payload_byte);
				errors++;
			end else begin
				w = expected_words.pop_front();
				check_field("result_kind", 64'(w.kind), 64'(out_ch.result_kind));
				check_field("fin_flag", 64'(w.fin), 64'(out_ch.fin_flag));
				check_field("frame_opcode", 64'(w.opcode), 64'(out_ch.frame_opcode));
				check_field("masked_flag", 64'(w.masked), 64'(out_ch.masked_flag));
				check_field("payload_length", 64'(w.length), 64'(out_ch.payload_length));
				check_field("payload_byte", 64'(w.pbyte), 64'(out_ch.payload_byte));
				check_field("last_of_frame", 64'(w.last), 64'(out_ch.last_of_frame));
				check_field("close_frame", 64'(w.close), 64'(out_ch.close_frame));
				check_field("error_code", 64'(w.err), 64'(out_ch.error_code));
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("websocket_frame_deframer_top test failed");
			$finish;
		end
	end

	initial begin
		row_t        dir_rows[27];
		logic [3:0]  op;
		logic [7:0]  b;
		int          total;
		bit          held;
		errors = 0;
		sent = 0;
		cycles = 0;
		hold_asked = 0;
		hold_taken = 0;
		hold_left = 0;
		held = 1'b0;
		send_idle = 26;
		recv_idle = 57;
		m_st = ST_FIRST;
		m_cnt = '0;
		m_fin = 1'b0;
		m_op = '0;
		m_mask = 1'b0;
		m_len = '0;
		m_key = '0;
		m_off = '0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		dir_rows = '{
			'{8'h80, 1'b0, NO_WORD},
			'{8'h00, 1'b1, typed_word(KIND_HEADER, 1'b1, OP_CONT, 1'b0, 64'd0, 1'b1, 1'b0,
				1'b0)},
			'{8'h01, 1'b0, NO_WORD},
			'{8'h00, 1'b1, typed_word(KIND_HEADER, 1'b0, OP_TEXT, 1'b0, 64'd0, 1'b1, 1'b0,
				1'b0)},
			// masked binary, one byte
			'{8'h82, 1'b0, NO_WORD},
			'{8'h81, 1'b0, NO_WORD},
			'{8'h12, 1'b0, NO_WORD},
			'{8'h34, 1'b0, NO_WORD},
			'{8'h56, 1'b0, NO_WORD},
			'{8'h78, 1'b0, NO_WORD},
			'{8'hFF, 1'b0, NO_WORD},
			// close, 64-bit length of zero
			'{8'h88, 1'b0, NO_WORD},
			'{8'h7F, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b1, typed_word(KIND_HEADER, 1'b1, OP_CLOSE, 1'b0, 64'd0, 1'b1, 1'b1,
				1'b0)},
			// ping, 16-bit length of zero
			'{8'h09, 1'b0, NO_WORD},
			'{8'h7E, 1'b0, NO_WORD},
			'{8'h00, 1'b0, NO_WORD},
			'{8'h00, 1'b1, typed_word(KIND_HEADER, 1'b0, OP_PING, 1'b0, 64'd0, 1'b1, 1'b0,
				1'b0)},
			'{8'h8A, 1'b0, NO_WORD},
			'{8'h00, 1'b1, typed_word(KIND_HEADER, 1'b1, OP_PONG, 1'b0, 64'd0, 1'b1, 1'b0,
				1'b0)}
		};
		foreach (dir_rows[i])
			put_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

		total = sent + RANDOM_BYTES;
		while (sent < total) begin
			if (sent >= total - RANDOM_BYTES / 3) begin
				send_idle = 0;
				recv_idle = 0;
				if (!held) begin
					held = 1'b1;
					hold_asked++;
				end
			end else if (sent >= total - 2 * RANDOM_BYTES / 3) begin
				send_idle = 57;
				recv_idle = 26;
			end
			send_frame();
		end

		// an error or an endless frame can only close the run
		case ($urandom_range(2))
			0: begin
				do
					op = 4'($urandom_range(15));
				while (op_known(op));
				b = {1'($urandom_range(1)), 3'($urandom_range(7)), op};
				put_byte(b, 1'b1, typed_word(KIND_ERROR, b[7], op, 1'b0, 64'd0, 1'b0, 1'b0,
					ERR_OPCODE));
				for (int i = 0; i < 8; i++)
					put_byte(8'($urandom_range(255)), 1'b0, NO_WORD);
			end
			1: begin
				do
					op = 4'($urandom_range(15));
				while (!op_known(op));
				b = {1'($urandom_range(1)), 3'($urandom_range(1, 7)), op};
				put_byte(b, 1'b1, typed_word(KIND_ERROR, b[7], op, 1'b0, 64'd0, 1'b0,
					op == OP_CLOSE, ERR_RESERVED));
				put_byte(8'h81, 1'b0, NO_WORD);
				put_byte(8'h00, 1'b0, NO_WORD);
				for (int i = 0; i < 6; i++)
					put_byte(8'($urandom_range(255)), 1'b0, NO_WORD);
			end
			default: begin
				put_byte(8'h82, 1'b0, NO_WORD);
				for (int i = 0; i < 9; i++)
					put_byte(8'hFF, 1'b0, NO_WORD);
				for (int i = 0; i < 28; i++)
					put_byte(8'($urandom_range(255)), 1'b0, NO_WORD);
			end
		endcase
		in_ch.valid <= 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("websocket_frame_deframer_top test passed");
		else
			$display("websocket_frame_deframer_top test failed");
		$finish;
	end

endmodule

/* files.f */
src/wsd_pkg.sv
src/wsd_in_if.sv
src/wsd_out_if.sv
src/wsd_in_stage.sv
src/wsd_parser.sv
src/websocket_frame_deframer_top.sv
sim/websocket_frame_deframer_top_test.sv
